### rtl/modular_exponentiation_macros.svh
// ----------------------------------------------------------------------------
// Modular exponentiation assertion macros
// Shorthand for clocked implication checks with a synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define MODEXP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define MODEXP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/modexp_pkg.sv
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Field widths, modulus, reduction constants and shared multiplier types.
// ----------------------------------------------------------------------------
package modexp_pkg;

    localparam int BASE_W   = 31;
    localparam int EXP_W    = 31;
    localparam int RES_W    = 30;
    localparam int EXP_BITS = 31;

    // Only the low EXP_BITS exponent bits take part
    localparam int EXP_USE = (EXP_BITS < EXP_W) ? EXP_BITS : EXP_W;
    localparam logic [EXP_W-1:0] EXP_MASK = EXP_W'((64'd1 << EXP_USE) - 64'd1);

    localparam logic [RES_W-1:0] MODULUS = 30'd1000000007;

    // Multiplier operands are at most 31 bits (the raw base), product below 2^62
    localparam int OPD_W    = 31;
    localparam int PROD_W   = 2 * OPD_W;
    // Barrett reduction: q = ((P >> SHIFT_LO) * MU) >> QX_W, MU = 2^62 / M
    localparam int SHIFT_LO = 29;
    localparam int QX_W     = PROD_W - SHIFT_LO;
    localparam int MU_W     = 33;
    localparam int EST_W    = QX_W + MU_W;
    localparam int Q_W      = EST_W - QX_W;
    localparam int QM_W     = Q_W + RES_W;
    // Remainder estimate stays below 3 * M, so 32 bits carry it exactly
    localparam int REM_W    = 32;

    localparam logic [63:0] MU_FULL = (64'd1 << (SHIFT_LO + QX_W)) / 64'(MODULUS);
    localparam logic [MU_W-1:0] MU = MU_FULL[MU_W-1:0];

    typedef logic [BASE_W-1:0] t_base;
    typedef logic [EXP_W-1:0]  t_exp;
    typedef logic [RES_W-1:0]  t_residue;
    typedef logic [OPD_W-1:0]  t_operand;

    typedef enum logic {
        DEST_ACC,
        DEST_RUN
    } t_dest;

    typedef struct packed {
        logic     valid;
        t_dest    dest;
        t_operand a;
        t_operand b;
    } t_mm_req;

    typedef struct packed {
        logic     valid;
        t_dest    dest;
        t_residue value;
    } t_mm_rsp;

endpackage

### rtl/modexp_in_if.sv
// ----------------------------------------------------------------------------
// Modular exponentiation input channel
// Valid/ready stream carrying one base and exponent per item.
// ----------------------------------------------------------------------------
interface modexp_in_if;
    import modexp_pkg::*;

    logic  valid;
    logic  ready;
    t_base base;
    t_exp  exponent;

    modport source (output valid, output base, output exponent, input ready);
    modport sink   (input valid, input base, input exponent, output ready);
endinterface

### rtl/modexp_out_if.sv
// ----------------------------------------------------------------------------
// Modular exponentiation output channel
// Valid/ready stream carrying one power_mod result per item.
// ----------------------------------------------------------------------------
interface modexp_out_if;
    import modexp_pkg::*;

    logic     valid;
    logic     ready;
    t_residue power_mod;

    modport source (output valid, output power_mod, input ready);
    modport sink   (input valid, input power_mod, output ready);
endinterface

### rtl/modexp_mulmod.sv
// ----------------------------------------------------------------------------
// Modular multiplier
// Three-stage pipelined a * b mod 1000000007 with Barrett reduction; one
// request per cycle, the destination tag travels with the product.
// ----------------------------------------------------------------------------
module modexp_mulmod (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  modexp_pkg::t_mm_req i_req,
    output modexp_pkg::t_mm_rsp o_rsp
);
    import modexp_pkg::*;

    localparam logic [REM_W-1:0] MOD_X1 = REM_W'(64'(MODULUS));
    localparam logic [REM_W-1:0] MOD_X2 = REM_W'(64'(MODULUS) * 64'd2);

    logic              r_s1_valid, r_s2_valid, r_s3_valid;
    t_dest             r_s1_dest, r_s2_dest, r_s3_dest;
    logic [PROD_W-1:0] r_prod;
    logic [REM_W-1:0]  r_s2_lo;
    logic [EST_W-1:0]  r_s2_est;
    logic [REM_W-1:0]  r_s3_rem;

    logic [Q_W-1:0]    q;
    logic [QM_W-1:0]   qm;
    logic [REM_W-1:0]  n_rem;
    logic [REM_W-1:0]  rem_fix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_req.valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    // quotient estimate is at most two below the true quotient
    assign q     = r_s2_est[EST_W-1 -: Q_W];
    assign qm    = QM_W'(q) * QM_W'(MODULUS);
    assign n_rem = r_s2_lo - qm[REM_W-1:0];

    always_ff @(posedge i_clk) begin
        r_s1_dest <= i_req.dest;
        r_prod    <= PROD_W'(i_req.a) * PROD_W'(i_req.b);
        r_s2_dest <= r_s1_dest;
        r_s2_lo   <= r_prod[REM_W-1:0];
        r_s2_est  <= EST_W'(r_prod[PROD_W-1:SHIFT_LO]) * EST_W'(MU);
        r_s3_dest <= r_s2_dest;
        r_s3_rem  <= n_rem;
    end

    // final correction: remainder below 3 * M
    always_comb begin
        if (r_s3_rem >= MOD_X2) begin
            rem_fix = r_s3_rem - MOD_X2;
        end else if (r_s3_rem >= MOD_X1) begin
            rem_fix = r_s3_rem - MOD_X1;
        end else begin
            rem_fix = r_s3_rem;
        end
    end

    assign o_rsp.valid = r_s3_valid;
    assign o_rsp.dest  = r_s3_dest;
    assign o_rsp.value = rem_fix[RES_W-1:0];

endmodule

### rtl/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// Modular exponentiation (base^exponent mod 1000000007), square-and-multiply
// Per exponent bit up to the highest set one: SQUARE, MULT, WAIT0, WAIT1, SHIFT
//   (none for a zero exponent); EMIT then waits for a free output register.
// One item at a time, on the 3-stage shared multiplier; the next is taken at LOAD.
// Synchronous active-low reset returns the sequencer to its load step.
// ----------------------------------------------------------------------------
module modular_exponentiation (
    input  logic         i_clk,
    input  logic         i_rst_n,
    modexp_in_if.sink    i_in,
    modexp_out_if.source o_out
);
    import modexp_pkg::*;

    localparam int PC_W = 3;

    localparam logic [PC_W-1:0] ST_LOAD   = 3'd0;
    localparam logic [PC_W-1:0] ST_SQUARE = 3'd1;
    localparam logic [PC_W-1:0] ST_MULT   = 3'd2;
    localparam logic [PC_W-1:0] ST_WAIT0  = 3'd3;
    localparam logic [PC_W-1:0] ST_WAIT1  = 3'd4;
    localparam logic [PC_W-1:0] ST_SHIFT  = 3'd5;
    localparam logic [PC_W-1:0] ST_EMIT   = 3'd6;

    typedef enum logic [1:0] {
        ISS_NONE,
        ISS_SQUARE,
        ISS_MULT_IF_BIT
    } t_issue;

    typedef enum logic [1:0] {
        BR_NEXT,
        BR_LOAD,
        BR_LOOP,
        BR_EMIT
    } t_branch;

    typedef struct packed {
        logic            load;
        t_issue          issue;
        logic            shift;
        logic            emit;
        t_branch         branch;
        logic [PC_W-1:0] target;
    } t_uword;

    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        w = '{load: 1'b0, issue: ISS_NONE, shift: 1'b0, emit: 1'b0,
              branch: BR_NEXT, target: ST_LOAD};
        case (pc)
            ST_LOAD: begin
                w.load   = 1'b1;
                w.branch = BR_LOAD;
                w.target = ST_EMIT;
            end
            ST_SQUARE: begin
                w.issue = ISS_SQUARE;
            end
            ST_MULT: begin
                w.issue = ISS_MULT_IF_BIT;
            end
            ST_WAIT0, ST_WAIT1: begin
                w.branch = BR_NEXT;
            end
            ST_SHIFT: begin
                w.shift  = 1'b1;
                w.branch = BR_LOOP;
                w.target = ST_SQUARE;
            end
            ST_EMIT: begin
                w.emit   = 1'b1;
                w.branch = BR_EMIT;
                w.target = ST_LOAD;
            end
            default: begin
                w.branch = BR_EMIT;
                w.target = ST_LOAD;
            end
        endcase
        return w;
    endfunction

    logic [PC_W-1:0] r_pc, n_pc;
    t_base           r_run;
    t_residue        r_acc;
    t_exp            r_exp;
    logic            r_out_valid;
    t_residue        r_out_data;

    t_uword  uw;
    t_mm_req mm_req;
    t_mm_rsp mm_rsp;
    logic    in_hs;
    logic    out_free;
    t_exp    load_exp;
    t_exp    exp_shifted;

    assign uw          = ucode(r_pc);
    assign in_hs       = i_in.valid & uw.load;
    assign out_free    = ~r_out_valid | o_out.ready;
    assign load_exp    = i_in.exponent & EXP_MASK;
    assign exp_shifted = r_exp >> 1;

    assign i_in.ready      = uw.load;
    assign o_out.valid     = r_out_valid;
    assign o_out.power_mod = r_out_data;

    // issue to the shared multiplier; both products use the pre-square base
    always_comb begin
        mm_req.valid = 1'b0;
        mm_req.dest  = DEST_RUN;
        mm_req.a     = r_run;
        mm_req.b     = r_run;
        case (uw.issue)
            ISS_SQUARE: begin
                mm_req.valid = 1'b1;
            end
            ISS_MULT_IF_BIT: begin
                mm_req.valid = r_exp[0];
                mm_req.dest  = DEST_ACC;
                mm_req.a     = OPD_W'(r_acc);
            end
            default: begin
                mm_req.valid = 1'b0;
            end
        endcase
    end

    modexp_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mm_req),
        .o_rsp   (mm_rsp)
    );

    always_comb begin
        case (uw.branch)
            BR_NEXT: begin
                n_pc = r_pc + 3'd1;
            end
            BR_LOAD: begin
                if (!in_hs) begin
                    n_pc = r_pc;
                end else if (load_exp == '0) begin
                    n_pc = uw.target;
                end else begin
                    n_pc = r_pc + 3'd1;
                end
            end
            BR_LOOP: begin
                n_pc = (exp_shifted != '0) ? uw.target : r_pc + 3'd1;
            end
            BR_EMIT: begin
                n_pc = out_free ? uw.target : r_pc;
            end
            default: begin
                n_pc = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= ST_LOAD;
            r_out_valid <= 1'b0;
        end else begin
            r_pc <= n_pc;
            if (uw.emit && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_hs) begin
            r_run <= i_in.base;
            r_exp <= load_exp;
            r_acc <= RES_W'(1);
        end else begin
            if (uw.shift) begin
                r_exp <= exp_shifted;
            end
            if (mm_rsp.valid && mm_rsp.dest == DEST_RUN) begin
                r_run <= BASE_W'(mm_rsp.value);
            end
            if (mm_rsp.valid && mm_rsp.dest == DEST_ACC) begin
                r_acc <= mm_rsp.value;
            end
        end
        if (uw.emit && out_free) begin
            r_out_data <= r_acc;
        end
    end

endmodule

### rtl/modexp_checker.sv
// ----------------------------------------------------------------------------
// Modular exponentiation port checker
// Watches the top-level channels for output hold, range and one-at-a-time use.
// ----------------------------------------------------------------------------
`include "modular_exponentiation_macros.svh"

module modexp_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 i_in_ready,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input modexp_pkg::t_residue i_power_mod
);
    import modexp_pkg::*;

    logic in_acc;
    logic out_stall;

    assign in_acc    = i_in_valid & i_in_ready;
    assign out_stall = i_out_valid & ~i_out_ready;

    `MODEXP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, i_out_valid, "result dropped")
    `MODEXP_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, out_stall, $stable(i_power_mod), "result changed")
    `MODEXP_ASSERT_SAME(a_out_range, i_clk, i_rst_n, i_out_valid, i_power_mod < MODULUS, "result not reduced")
    `MODEXP_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, in_acc, !i_in_ready, "second item taken too early")

endmodule

bind modular_exponentiation modexp_checker u_modexp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_power_mod (o_out.power_mod)
);

### sim/tb_modular_exponentiation.sv
// ----------------------------------------------------------------------------
// Modular exponentiation testbench
// Drives base/exponent items through the valid/ready input channel and checks
// every power_mod result in order against a square-and-multiply predictor.
// Runs a short directed set of corner cases, then random items in four idle
// patterns: none, sender gaps, receiver stalls, and light gaps on both sides.
// ----------------------------------------------------------------------------
module tb_modular_exponentiation;
    timeunit 1ns;
    timeprecision 1ps;

    import modexp_pkg::*;

    localparam int ITEMS_PER_PHASE = 200;
    localparam int TAIL_CYCLES     = 200;
    localparam t_base BASE_MAX     = '1;
    localparam t_exp  EXP_MAX      = '1;
    localparam t_base MOD_BASE     = t_base'(MODULUS);
    localparam t_exp  MOD_EXP      = t_exp'(MODULUS);

    class modexp_scoreboard;
        t_residue expected_powers[$];
        int       errors;

        function new();
            errors = 0;
        endfunction

        // Right-to-left square-and-multiply over the scanned exponent bits
        function t_residue predict_power(t_base b, t_exp e);
            longint unsigned acc;
            longint unsigned run;
            longint unsigned m;
            t_exp            bits;
            acc  = 1;
            run  = longint'(b);
            m    = longint'(MODULUS);
            bits = e & EXP_MASK;
            for (int i = 0; i < EXP_USE; i++) begin
                if (bits[i]) begin
                    acc = (acc * run) % m;
                end
                run = (run * run) % m;
            end
            return t_residue'(acc);
        endfunction

        function void note_input(t_base b, t_exp e);
            expected_powers.push_back(predict_power(b, e));
        endfunction

        function void check_result(t_residue got);
            t_residue want;
            if (expected_powers.size() == 0) begin
                $display("%0t: unexpected result power_mod=%0d", $time, got);
                errors++;
            end else begin
                want = expected_powers.pop_front();
                if (got !== want) begin
                    $display("%0t: power_mod mismatch: expected %0d, actual %0d",
                             $time, want, got);
                    errors++;
                end
            end
        endfunction

        function int outstanding();
            return expected_powers.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    modexp_in_if  in_ch();
    modexp_out_if out_ch();

    modular_exponentiation u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    modexp_scoreboard sb = new();
    int src_idle_pct = 0;
    int snk_stall_pct = 0;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #6 i_clk = ~i_clk;
    end

    // Result side: check accepted items, then pick ready for the next cycle
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            sb.check_result(out_ch.power_mod);
        end
        out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    task automatic send_item(t_base b, t_exp e);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.base     <= b;
        in_ch.exponent <= e;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
        sb.note_input(b, e);
    endtask

    // Hold the input idle until every expected result is back
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.outstanding() != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic t_base random_base();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 10) begin
            return t_base'($urandom_range(3));
        end else if (pick < 20) begin
            // land on or next to a multiple of the modulus
            return t_base'($urandom_range(2)) * MOD_BASE + t_base'($urandom_range(2))
                   - t_base'($urandom_range(1));
        end
        return t_base'($urandom);
    endfunction

    function automatic t_exp random_exponent();
        int unsigned w;
        w = ($urandom_range(1) == 0) ? EXP_W : $urandom_range(EXP_W);
        if (w == 0) begin
            return '0;
        end
        return t_exp'($urandom) & t_exp'((64'd1 << w) - 64'd1);
    endfunction

    task automatic run_phase(int idle_pct, int stall_pct);
        src_idle_pct  = idle_pct;
        snk_stall_pct = stall_pct;
        for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            send_item(random_base(), random_exponent());
        end
        drain();
    endtask

    initial begin
        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.base     = '0;
        in_ch.exponent = '0;
        out_ch.ready   = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero exponent with zero, maximal and modulus-multiple bases, then bases 0, 1, 2, M-1
        send_item('0, '0);
        send_item(BASE_MAX, '0);
        send_item(MOD_BASE, '0);
        send_item(MOD_BASE * t_base'(2), '0);
        send_item('0, t_exp'(1));
        send_item('0, EXP_MAX);
        send_item(t_base'(1), EXP_MAX);
        send_item(t_base'(2), t_exp'(30));
        send_item(t_base'(2), EXP_MAX);
        send_item(MOD_BASE - t_base'(1), t_exp'(1));
        send_item(MOD_BASE - t_base'(1), t_exp'(2));
        send_item(MOD_BASE - t_base'(1), EXP_MAX);
        // Bases at or above the modulus
        send_item(MOD_BASE, t_exp'(5));
        send_item(MOD_BASE + t_base'(1), EXP_MAX);
        send_item(MOD_BASE * t_base'(2) + t_base'(2), t_exp'(3));
        send_item(BASE_MAX, t_exp'(1));
        send_item(BASE_MAX, EXP_MAX);
        send_item(BASE_MAX, t_exp'(1) << (EXP_W - 1));
        // Fermat: b^(p-1) is 1, b^(p-2) is the inverse
        send_item(t_base'(12345), MOD_EXP - t_exp'(1));
        send_item(t_base'(12345), MOD_EXP - t_exp'(2));
        send_item(t_base'(32'h5555_5555), t_exp'(32'h2AAA_AAAA));
        send_item(t_base'(32'h2AAA_AAAA), t_exp'(32'h5555_5555));
        drain();

        run_phase(0, 0);
        run_phase(56, 0);
        run_phase(0, 56);
        run_phase(9, 9);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #(20_000_000);
        $display("tb: failure");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/modexp_pkg.sv
rtl/modexp_in_if.sv
rtl/modexp_out_if.sv
rtl/modexp_mulmod.sv
rtl/modular_exponentiation.sv
rtl/modexp_checker.sv
sim/tb_modular_exponentiation.sv
